// ===== hw/rtl/pjac_pkg.sv =====
// shared types, constants and rounding helpers for the pose jacobian block
package pjac_pkg;

  localparam int QBITS   = 30;
  localparam int NW      = 98;
  localparam int QB      = 33;
  localparam int DIV_LAT = QB + 2;

  localparam logic [7:0] REG_FOCAL_X        = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y        = 8'd1;
  localparam logic [7:0] REG_FOCAL_BASELINE = 8'd2;
  localparam logic [7:0] REG_STEREO_MODE    = 8'd3;

  localparam logic [1:0] ROW_U = 2'd0;
  localparam logic [1:0] ROW_V = 2'd1;
  localparam logic [1:0] ROW_R = 2'd2;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } pjac_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] jac_0;
    logic signed [31:0] jac_1;
    logic signed [31:0] jac_2;
    logic signed [31:0] jac_3;
    logic signed [31:0] jac_4;
    logic signed [31:0] jac_5;
    logic               last_row;
    logic               saturated;
  } pjac_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pre;
  } pjac_pc_t;

  typedef struct packed {
    logic        nx;
    logic        ny;
    logic        nz;
    logic        kneg;
    logic        pre;
    logic [63:0] zsq;
    logic [31:0] az;
    logic [31:0] ay;
    logic [63:0] fxax;
    logic [63:0] fyax;
    logic [63:0] fyay;
    logic [63:0] fxay;
    logic [63:0] bfax;
    logic [63:0] klo;
  } pjac_side_t;

  typedef struct packed {
    pjac_side_t  side;
    logic [95:0] fxsx;
    logic [95:0] fysy;
    logic [95:0] fxaxay;
    logic [95:0] fyaxay;
    logic [95:0] aykl;
    logic        j21_neg;
    logic [96:0] j21_mag;
  } pjac_num_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] row;
    logic       last;
    logic       pre;
  } pjac_meta_t;

  // round to nearest, ties away from zero, then shift down
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? $signed(64'(-m)) : $signed(m);
  endfunction

  function automatic logic fits32(input logic signed [39:0] v);
    return (v[39:31] == '0) || (v[39:31] == '1);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [39:0] v);
    if (fits32(v)) return v[31:0];
    return v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// ===== hw/rtl/pjac_xform.sv =====
// rotation matrix build and point transform into the camera frame
module pjac_xform import pjac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  pjac_in_t in_data,
  output logic     pc_vld,
  output pjac_pc_t pc
);

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [63:0] pp_r [9];
  logic signed [63:0] pp_nxt [9];
  logic signed [31:0] t1_r [3], p1_r [3], t2_r [3], p2_r [3], t3_r [3];
  logic signed [31:0] rm_r [9];
  logic signed [31:0] rm_nxt [9];
  logic               pre2_r, pre2_nxt, pre3_r;
  logic signed [63:0] rp_r [9];
  logic signed [63:0] rp_nxt [9];
  pjac_pc_t           pc_r, pc_nxt;

  // pair products: xx yy zz xy xz yz wx wy wz
  always_comb begin
    pp_nxt[0] = in_data.quat_x * in_data.quat_x;
    pp_nxt[1] = in_data.quat_y * in_data.quat_y;
    pp_nxt[2] = in_data.quat_z * in_data.quat_z;
    pp_nxt[3] = in_data.quat_x * in_data.quat_y;
    pp_nxt[4] = in_data.quat_x * in_data.quat_z;
    pp_nxt[5] = in_data.quat_y * in_data.quat_z;
    pp_nxt[6] = in_data.quat_w * in_data.quat_x;
    pp_nxt[7] = in_data.quat_w * in_data.quat_y;
    pp_nxt[8] = in_data.quat_w * in_data.quat_z;
  end

  always_comb begin
    logic signed [39:0] e [9];
    logic signed [39:0] r [9];
    logic signed [39:0] one;
    one = 40'sd1 <<< QBITS;
    for (int k = 0; k < 9; k++) begin
      e[k] = 40'(rnd_shift(pp_r[k], QBITS));
    end
    r[0] = one - 40'sd2 * (e[1] + e[2]);
    r[1] = 40'sd2 * (e[3] - e[8]);
    r[2] = 40'sd2 * (e[4] + e[7]);
    r[3] = 40'sd2 * (e[3] + e[8]);
    r[4] = one - 40'sd2 * (e[0] + e[2]);
    r[5] = 40'sd2 * (e[5] - e[6]);
    r[6] = 40'sd2 * (e[4] - e[7]);
    r[7] = 40'sd2 * (e[5] + e[6]);
    r[8] = one - 40'sd2 * (e[0] + e[1]);
    pre2_nxt = 1'b0;
    for (int k = 0; k < 9; k++) begin
      rm_nxt[k] = clamp32(r[k]);
      if (!fits32(r[k])) pre2_nxt = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        rp_nxt[i*3+c] = rm_r[i*3+c] * p2_r[c];
      end
    end
  end

  always_comb begin
    logic signed [39:0] acc [3];
    pc_nxt.pre = pre3_r;
    for (int i = 0; i < 3; i++) begin
      acc[i] = 40'(t3_r[i]) + 40'(rnd_shift(rp_r[i*3], QBITS))
             + 40'(rnd_shift(rp_r[i*3+1], QBITS)) + 40'(rnd_shift(rp_r[i*3+2], QBITS));
      if (!fits32(acc[i])) pc_nxt.pre = 1'b1;
    end
    pc_nxt.x = clamp32(acc[0]);
    pc_nxt.y = clamp32(acc[1]);
    pc_nxt.z = clamp32(acc[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_r   <= pp_nxt;
    t1_r   <= '{in_data.trans_x, in_data.trans_y, in_data.trans_z};
    p1_r   <= '{in_data.point_x, in_data.point_y, in_data.point_z};
    rm_r   <= rm_nxt;
    pre2_r <= pre2_nxt;
    t2_r   <= t1_r;
    p2_r   <= p1_r;
    rp_r   <= rp_nxt;
    pre3_r <= pre2_r;
    t3_r   <= t2_r;
    pc_r   <= pc_nxt;
  end

  assign pc_vld = v4_r;
  assign pc     = pc_r;

endmodule

// ===== hw/rtl/pjac_numer.sv =====
// projection terms and wide numerators of the jacobian entries
module pjac_numer import pjac_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pc_vld,
  input  pjac_pc_t    pc,
  input  logic [31:0] fx,
  input  logic [31:0] fy,
  input  logic [31:0] bf,
  output logic        num_vld,
  output pjac_num_t   num
);

  logic        va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic        nx_a_r, ny_a_r, nz_a_r, pre_a_r;
  logic [31:0] ax_a_r, ay_a_r, az_a_r;
  logic        nx_b_r, ny_b_r, nz_b_r, pre_b_r;
  logic [31:0] ay_b_r, az_b_r;
  logic [63:0] zsq_b_r, axx_b_r, ayy_b_r, fxax_b_r, fyax_b_r, fyay_b_r, bfax_b_r, fxay_b_r;
  pjac_side_t  side_c_r, side_c_nxt, side_d_r, side_e_r;
  logic [63:0] sx_c_r, sy_c_r;
  logic [63:0] ml_d_r [5];
  logic [63:0] mh_d_r [5];
  logic [31:0] ma [5];
  logic [63:0] mb [5];
  logic [95:0] big_e_r [5];
  logic [95:0] big_nxt [5];
  pjac_num_t   num_r, num_nxt;

  // stage c: denominators and the disparity term k
  always_comb begin
    logic [63:0] bff;
    logic [64:0] ksum;
    bff        = 64'(bf) << FRAC_BITS;
    ksum       = {1'b0, fxax_b_r} + {1'b0, bff};
    side_c_nxt = '0;
    side_c_nxt.nx   = nx_b_r;
    side_c_nxt.ny   = ny_b_r;
    side_c_nxt.nz   = nz_b_r;
    side_c_nxt.pre  = pre_b_r;
    side_c_nxt.zsq  = zsq_b_r;
    side_c_nxt.az   = az_b_r;
    side_c_nxt.ay   = ay_b_r;
    side_c_nxt.fxax = fxax_b_r;
    side_c_nxt.fyax = fyax_b_r;
    side_c_nxt.fyay = fyay_b_r;
    side_c_nxt.fxay = fxay_b_r;
    side_c_nxt.bfax = bfax_b_r;
    if (nx_b_r) begin
      side_c_nxt.kneg = 1'b1;
      side_c_nxt.klo  = ksum[63:0];
    end else if (fxax_b_r >= bff) begin
      side_c_nxt.kneg = 1'b0;
      side_c_nxt.klo  = fxax_b_r - bff;
    end else begin
      side_c_nxt.kneg = 1'b1;
      side_c_nxt.klo  = bff - fxax_b_r;
    end
  end

  // stage d operands: fx*sx, fy*sy, fxax*ay, fyax*ay, k*ay
  always_comb begin
    ma[0] = fx;          mb[0] = sx_c_r;
    ma[1] = fy;          mb[1] = sy_c_r;
    ma[2] = side_c_r.ay; mb[2] = side_c_r.fxax;
    ma[3] = side_c_r.ay; mb[3] = side_c_r.fyax;
    ma[4] = side_c_r.ay; mb[4] = side_c_r.klo;
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      big_nxt[i] = (96'(mh_d_r[i]) << 32) + 96'(ml_d_r[i]);
    end
  end

  always_comb begin
    logic [96:0] bfaxf;
    logic [96:0] fxsx;
    bfaxf          = 97'(side_e_r.bfax) << FRAC_BITS;
    fxsx           = 97'(big_e_r[0]);
    num_nxt.side   = side_e_r;
    num_nxt.fxsx   = big_e_r[0];
    num_nxt.fysy   = big_e_r[1];
    num_nxt.fxaxay = big_e_r[2];
    num_nxt.fyaxay = big_e_r[3];
    num_nxt.aykl   = big_e_r[4];
    if (side_e_r.nx) begin
      num_nxt.j21_neg = 1'b1;
      num_nxt.j21_mag = fxsx + bfaxf;
    end else if (fxsx >= bfaxf) begin
      num_nxt.j21_neg = 1'b1;
      num_nxt.j21_mag = fxsx - bfaxf;
    end else begin
      num_nxt.j21_neg = 1'b0;
      num_nxt.j21_mag = bfaxf - fxsx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      va_r <= pc_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    nx_a_r   <= pc.x[31];
    ny_a_r   <= pc.y[31];
    nz_a_r   <= pc.z[31];
    ax_a_r   <= pc.x[31] ? (~pc.x + 32'd1) : pc.x;
    ay_a_r   <= pc.y[31] ? (~pc.y + 32'd1) : pc.y;
    az_a_r   <= pc.z[31] ? (~pc.z + 32'd1) : pc.z;
    pre_a_r  <= pc.pre || (pc.z == '0);
    nx_b_r   <= nx_a_r;
    ny_b_r   <= ny_a_r;
    nz_b_r   <= nz_a_r;
    pre_b_r  <= pre_a_r;
    ay_b_r   <= ay_a_r;
    az_b_r   <= az_a_r;
    zsq_b_r  <= az_a_r * az_a_r;
    axx_b_r  <= ax_a_r * ax_a_r;
    ayy_b_r  <= ay_a_r * ay_a_r;
    fxax_b_r <= fx * ax_a_r;
    fyax_b_r <= fy * ax_a_r;
    fyay_b_r <= fy * ay_a_r;
    bfax_b_r <= bf * ax_a_r;
    fxay_b_r <= fx * ay_a_r;
    side_c_r <= side_c_nxt;
    sx_c_r   <= zsq_b_r + axx_b_r;
    sy_c_r   <= zsq_b_r + ayy_b_r;
    side_d_r <= side_c_r;
    for (int i = 0; i < 5; i++) begin
      ml_d_r[i] <= ma[i] * mb[i][31:0];
      mh_d_r[i] <= ma[i] * mb[i][63:32];
    end
    side_e_r <= side_d_r;
    big_e_r  <= big_nxt;
    num_r    <= num_nxt;
  end

  assign num_vld = vf_r;
  assign num     = num_r;

endmodule

// ===== hw/rtl/pjac_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module pjac_div import pjac_pkg::*; (
  input  logic          clk,
  input  logic          num_neg,
  input  logic [NW-1:0] num,
  input  logic [63:0]   den,
  output logic [31:0]   quo,
  output logic          sat
);

  logic [63:0]   rem_r  [QB+1];
  logic [QB-1:0] lq_r   [QB+1];
  logic [63:0]   den_r  [QB+1];
  logic          neg_r  [QB+1];
  logic          ovf_r  [QB+1];
  logic          zero_r [QB+1];
  logic [31:0]   quo_r;
  logic          sat_r;
  logic [31:0]   quo_r_nxt;
  logic          sat_nxt;

  // quotient of 2^QB or more always saturates
  always_ff @(posedge clk) begin
    rem_r[0]  <= num[NW-2:QB];
    lq_r[0]   <= num[QB-1:0];
    den_r[0]  <= den;
    neg_r[0]  <= num_neg;
    ovf_r[0]  <= num[NW-1:QB] >= {1'b0, den};
    zero_r[0] <= (num == '0);
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [64:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_r[s], lq_r[s][QB-1]};
      ge    = trial >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      rem_r[s+1]  <= ge ? 64'(trial - {1'b0, den_r[s]}) : trial[63:0];
      lq_r[s+1]   <= {lq_r[s][QB-2:0], ge};
      den_r[s+1]  <= den_r[s];
      neg_r[s+1]  <= neg_r[s];
      ovf_r[s+1]  <= ovf_r[s];
      zero_r[s+1] <= zero_r[s];
    end
  end

  always_comb begin : fin
    logic [QB:0] qr;
    logic [QB:0] lim;
    logic [31:0] qs;
    logic        over;
    qr   = {1'b0, lq_r[QB]} + (QB+1)'({rem_r[QB], 1'b0} >= {1'b0, den_r[QB]});
    lim  = neg_r[QB] ? (QB+1)'(33'h0_8000_0000) : (QB+1)'(33'h0_7FFF_FFFF);
    over = ovf_r[QB] || (qr > lim);
    if (ovf_r[QB] && zero_r[QB]) qs = '0;
    else if (over)               qs = lim[31:0];
    else                         qs = qr[31:0];
    quo_r_nxt = neg_r[QB] ? (~qs + 32'd1) : qs;
    sat_nxt   = over;
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_r_nxt;
    sat_r <= sat_nxt;
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

// ===== hw/rtl/projection_pose_jacobian_top.sv =====
// top level: config registers, row sequencer, divider lanes and result register
// Takes one pose and world point per accepted start and delivers two jacobian rows
// (three in stereo mode) on out_valid in consecutive cycles, row u first, with
// last_row on the final one. A new item is taken once busy has fallen, while earlier
// items may still be in the pipeline: busy covers the cycles after an accept, since
// the single result channel carries one row per cycle and each row runs through
// the five divider lanes on its own. An accepted item passes through 4 transform
// stages, 6 numerator stages, the row hold register, 35 divider stages and the
// result register before its first row. Results are strobed for one cycle only and
// the receiver cannot hold them off. Configure only while no item is in flight.
module projection_pose_jacobian_top import pjac_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pjac_in_t    in_data,
  output logic        out_valid,
  output pjac_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]   cfg_fx_r, cfg_fy_r, cfg_bf_r;
  logic          cfg_stereo_r;
  logic [1:0]    gap_r, gap_nxt;
  logic          accept;
  logic          pc_vld;
  pjac_pc_t      pc;
  logic          num_vld;
  pjac_num_t     num;
  pjac_num_t     hold_r;
  logic          act_r, act_nxt;
  logic [1:0]    row_r, row_nxt, last_idx;
  logic          lane_neg [5];
  logic [NW-1:0] lane_num [5];
  logic [63:0]   lane_den [5];
  logic [31:0]   lane_quo [5];
  logic          lane_sat [5];
  pjac_meta_t    meta_r [DIV_LAT];
  pjac_meta_t    meta_nxt, meta_q;
  logic          out_valid_r;
  pjac_out_t     out_data_r, out_nxt;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (gap_r != 2'd0);
  assign last_idx  = cfg_stereo_r ? ROW_R : ROW_V;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fx_r     <= 32'd33554432;
      cfg_fy_r     <= 32'd33554432;
      cfg_bf_r     <= '0;
      cfg_stereo_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL_X:        cfg_fx_r     <= cfg_data;
        REG_FOCAL_Y:        cfg_fy_r     <= cfg_data;
        REG_FOCAL_BASELINE: cfg_bf_r     <= cfg_data;
        REG_STEREO_MODE:    cfg_stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (accept)              gap_nxt = cfg_stereo_r ? 2'd2 : 2'd1;
    else if (gap_r != 2'd0)  gap_nxt = gap_r - 2'd1;
    else                     gap_nxt = 2'd0;
  end

  pjac_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_data (in_data),
    .pc_vld  (pc_vld),
    .pc      (pc)
  );

  pjac_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
    .clk     (clk),
    .rst_n   (rst_n),
    .pc_vld  (pc_vld),
    .pc      (pc),
    .fx      (cfg_fx_r),
    .fy      (cfg_fy_r),
    .bf      (cfg_bf_r),
    .num_vld (num_vld),
    .num     (num)
  );

  // items arrive spaced by the row count, so a new one lands as the last row leaves
  always_comb begin
    if (num_vld) begin
      act_nxt = 1'b1;
      row_nxt = ROW_U;
    end else if (act_r && (row_r == last_idx)) begin
      act_nxt = 1'b0;
      row_nxt = ROW_U;
    end else begin
      act_nxt = act_r;
      row_nxt = act_r ? row_r + 2'd1 : row_r;
    end
  end

  always_comb begin
    logic [NW-1:0] fxf, fyf;
    fxf = NW'(cfg_fx_r) << FRAC_BITS;
    fyf = NW'(cfg_fy_r) << FRAC_BITS;
    for (int i = 0; i < 5; i++) begin
      lane_den[i] = hold_r.side.zsq;
    end
    lane_den[2] = 64'(hold_r.side.az);
    lane_den[3] = 64'(hold_r.side.az);
    lane_neg[2] = hold_r.side.ny ^ hold_r.side.nz;
    lane_num[2] = NW'(hold_r.side.fxay);
    lane_neg[3] = !hold_r.side.nz;
    lane_num[3] = fxf;
    case (row_r)
      ROW_V: begin
        lane_neg[0] = 1'b0;
        lane_num[0] = NW'(hold_r.fysy);
        lane_neg[1] = !(hold_r.side.nx ^ hold_r.side.ny);
        lane_num[1] = NW'(hold_r.fyaxay);
        lane_neg[2] = !(hold_r.side.nx ^ hold_r.side.nz);
        lane_num[2] = NW'(hold_r.side.fyax);
        lane_num[3] = fyf;
        lane_neg[4] = hold_r.side.ny;
        lane_num[4] = NW'(hold_r.side.fyay) << FRAC_BITS;
      end
      ROW_R: begin
        lane_neg[0] = hold_r.side.ny ^ hold_r.side.kneg;
        lane_num[0] = NW'(hold_r.aykl);
        lane_neg[1] = hold_r.j21_neg;
        lane_num[1] = NW'(hold_r.j21_mag);
        lane_neg[4] = hold_r.side.kneg;
        lane_num[4] = NW'(hold_r.side.klo) << FRAC_BITS;
      end
      default: begin
        lane_neg[0] = hold_r.side.nx ^ hold_r.side.ny;
        lane_num[0] = NW'(hold_r.fxaxay);
        lane_neg[1] = 1'b1;
        lane_num[1] = NW'(hold_r.fxsx);
        lane_neg[4] = hold_r.side.nx;
        lane_num[4] = NW'(hold_r.side.fxax) << FRAC_BITS;
      end
    endcase
  end

  for (genvar l = 0; l < 5; l++) begin : g_lane
    pjac_div u_div (
      .clk     (clk),
      .num_neg (lane_neg[l]),
      .num     (lane_num[l]),
      .den     (lane_den[l]),
      .quo     (lane_quo[l]),
      .sat     (lane_sat[l])
    );
  end

  always_comb begin
    meta_nxt.vld  = act_r;
    meta_nxt.row  = row_r;
    meta_nxt.last = (row_r == last_idx);
    meta_nxt.pre  = hold_r.side.pre;
  end

  assign meta_q = meta_r[DIV_LAT-1];

  // the right row shares the depth-only entries with row u but not their flags
  always_comb begin
    out_nxt.row_index = meta_q.row;
    out_nxt.last_row  = meta_q.last;
    out_nxt.jac_0     = lane_quo[0];
    out_nxt.jac_1     = lane_quo[1];
    out_nxt.jac_2     = lane_quo[2];
    out_nxt.jac_5     = lane_quo[4];
    if (meta_q.row == ROW_V) begin
      out_nxt.jac_3 = '0;
      out_nxt.jac_4 = lane_quo[3];
    end else begin
      out_nxt.jac_3 = lane_quo[3];
      out_nxt.jac_4 = '0;
    end
    out_nxt.saturated = meta_q.pre || lane_sat[0] || lane_sat[1] || lane_sat[4]
                     || ((meta_q.row != ROW_R) && (lane_sat[2] || lane_sat[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= '0;
      act_r       <= 1'b0;
      row_r       <= ROW_U;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) meta_r[i].vld <= 1'b0;
    end else begin
      gap_r       <= gap_nxt;
      act_r       <= act_nxt;
      row_r       <= row_nxt;
      out_valid_r <= meta_q.vld;
      meta_r[0]   <= meta_nxt;
      for (int i = 1; i < DIV_LAT; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (num_vld) hold_r <= num;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pjac_chk.sv =====
// port-level checks on the row stream and start handshake, bound to the top level
module pjac_chk import pjac_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input pjac_out_t out_data
);

  // rows of one item leave back to back
  a_rows_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |=> out_valid)
    else $error("row stream broken before last row");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |=> out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row index did not advance");

  a_new_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |=> !out_valid || out_data.row_index == ROW_U)
    else $error("item did not start at row u");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index != 2'd3)
    else $error("row index out of range");

endmodule

bind projection_pose_jacobian_top pjac_chk u_pjac_chk (.*);
